// ----- src/gvs_pkg.sv -----
`default_nettype none
package gvs_pkg;
	localparam int MAX_WORKERS_DEF = 64;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_DECIDE = 1'b1
	} req_type_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] worker_tag;
		logic        has_lease;
		logic [47:0] mem_bytes;
		logic        retriable;
		logic [31:0] owner_tag;
		logic [47:0] grant_time;
		logic        previous_alive;
	} in_word_t;

	typedef struct packed {
		logic        victim_valid;
		logic [15:0] victim_tag;
		logic        retry_task;
		logic        still_waiting;
		logic        table_overflow;
	} out_word_t;
endpackage
`default_nettype wire

// ----- src/grouped_victim_selector.sv -----
// A load word fills the next table entry (or flags overflow when full). A decide word walks
// the N stored entries, stopping after the idle scan when an idle worker is chosen, and needs
// no walk when the outstanding victim is still alive; table reads use the registered port.
// Throughput: loads back to back; a decide blocks input until its result word is taken.
// Reset (arst_n low, asynchronous): table empty, no overflow, no outstanding
// victim, threshold zero; table contents stay undefined until written.
`default_nettype none
module grouped_victim_selector #(
	parameter int MAX_WORKERS = gvs_pkg::MAX_WORKERS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [47:0]           cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire gvs_pkg::in_word_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output gvs_pkg::out_word_t   out_data
);
	import gvs_pkg::*;

	localparam int AW = $clog2(MAX_WORKERS);
	localparam int CW = $clog2(MAX_WORKERS + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_IDLE_SCAN = 7'b0000010,
		ST_LEAD  = 7'b0000100,
		ST_LEADCHK = 7'b0001000,
		ST_GRP   = 7'b0010000,
		ST_GEND  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [47:0] mem;
		logic [31:0] owner;
		logic [47:0] tm;
		logic        retry;
		logic        lease;
	} entry_t;

	state_t state_q;
	entry_t mem_q [MAX_WORKERS];
	entry_t rd_q;
	entry_t lead_q;
	logic [CW-1:0] count_q;
	logic overflow_q, pend_valid_q;
	logic [47:0] thresh_q;
	logic [AW-1:0] i_q, j_q;
	logic rd_pend_q;
	logic leader_ok_q;
	logic found_q;
	logic [47:0] best_mem_q;
	logic [15:0] best_tag_q;
	logic [CW-1:0] cnt_q;
	logic [47:0] mn_q, pick_tm_q;
	logic [15:0] pick_tag_q;
	logic have_q, b_ret_q;
	logic [CW-1:0] b_cnt_q;
	logic [47:0] b_min_q;
	logic [15:0] b_tag_q;
	out_word_t out_q;
	logic out_valid_q;

	logic [AW-1:0] rd_addr;
	logic same_grp;
	logic idle_hit;
	logic grp_better;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Shared compare: does the registered read fall in the leader's group
	assign same_grp = rd_q.lease && (rd_q.retry == lead_q.retry) &&
		(!rd_q.retry || rd_q.owner == lead_q.owner);

	// Idle candidate above threshold and above the running best
	assign idle_hit = !rd_q.lease && rd_q.mem > thresh_q && rd_q.mem > best_mem_q;

	always_comb begin
		if (!have_q) begin
			grp_better = 1'b1;
		end else if (lead_q.retry != b_ret_q) begin
			grp_better = lead_q.retry;
		end else if (cnt_q != b_cnt_q) begin
			grp_better = cnt_q > b_cnt_q;
		end else begin
			grp_better = mn_q > b_min_q;
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == REQ_LOAD && count_q < CW'(MAX_WORKERS)) begin
			mem_q[count_q[AW-1:0]] <= '{tag: in_data.worker_tag, mem: in_data.mem_bytes,
				owner: in_data.owner_tag, tm: in_data.grant_time,
				retry: in_data.retriable, lease: in_data.has_lease};
		end
		rd_q <= mem_q[rd_addr];
	end

	always_comb begin
		rd_addr = j_q;
	end

	// Sequencer over the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			overflow_q <= 1'b0;
			pend_valid_q <= 1'b0;
			thresh_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			i_q <= '0;
			j_q <= '0;
			rd_pend_q <= 1'b0;
			lead_q <= '0;
			leader_ok_q <= 1'b0;
			found_q <= 1'b0;
			best_mem_q <= '0;
			best_tag_q <= '0;
			cnt_q <= '0;
			mn_q <= '0;
			pick_tm_q <= '0;
			pick_tag_q <= '0;
			have_q <= 1'b0;
			b_ret_q <= 1'b0;
			b_cnt_q <= '0;
			b_min_q <= '0;
			b_tag_q <= '0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.req_type == REQ_LOAD) begin
							if (count_q < CW'(MAX_WORKERS)) begin
								count_q <= count_q + 1'b1;
							end else begin
								overflow_q <= 1'b1;
							end
						end else if (pend_valid_q && in_data.previous_alive) begin
							out_q <= '{victim_valid: 1'b0, victim_tag: '0, retry_task: 1'b0,
								still_waiting: 1'b1, table_overflow: overflow_q};
							out_valid_q <= 1'b1;
							count_q <= '0;
							overflow_q <= 1'b0;
						end else begin
							pend_valid_q <= 1'b0;
							found_q <= 1'b0;
							best_mem_q <= '0;
							have_q <= 1'b0;
							i_q <= '0;
							j_q <= '0;
							rd_pend_q <= 1'b0;
							state_q <= (count_q == '0) ? ST_FIN : ST_IDLE_SCAN;
						end
					end
				end
				ST_IDLE_SCAN: begin
					// Walk once for the largest idle worker above threshold
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (idle_hit) begin
							best_mem_q <= rd_q.mem;
							best_tag_q <= rd_q.tag;
							found_q <= 1'b1;
						end
						if (CW'(j_q) + 1'b1 == count_q) begin
							j_q <= '0;
							state_q <= (found_q || idle_hit) ? ST_FIN : ST_LEAD;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_LEAD: begin
					// Fetch candidate leader i (read address already points at i)
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						lead_q <= rd_q;
						cnt_q <= '0;
						mn_q <= '1;
						pick_tm_q <= rd_q.tm;
						pick_tag_q <= rd_q.tag;
						if (!rd_q.lease) begin
							leader_ok_q <= 1'b0;
							state_q <= ST_GEND;
						end else begin
							leader_ok_q <= 1'b1;
							if (i_q == '0) begin
								state_q <= ST_GRP;
							end else begin
								j_q <= '0;
								state_q <= ST_LEADCHK;
							end
						end
					end
				end
				ST_LEADCHK: begin
					// Any earlier entry in the same group disqualifies i
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (same_grp) begin
							state_q <= ST_GEND;
							leader_ok_q <= 1'b0;
						end else if (j_q + 1'b1 == i_q) begin
							j_q <= i_q;
							state_q <= ST_GRP;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_GRP: begin
					// Count members, earliest time, newest member
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (same_grp) begin
							cnt_q <= cnt_q + 1'b1;
							if (rd_q.tm < mn_q) begin
								mn_q <= rd_q.tm;
							end
							if (rd_q.tm > pick_tm_q) begin
								pick_tm_q <= rd_q.tm;
								pick_tag_q <= rd_q.tag;
							end
						end
						if (CW'(j_q) + 1'b1 == count_q) begin
							state_q <= ST_GEND;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_GEND: begin
					// Rank the finished group, advance the leader
					if (leader_ok_q && grp_better) begin
						have_q <= 1'b1;
						b_ret_q <= lead_q.retry;
						b_cnt_q <= cnt_q;
						b_min_q <= mn_q;
						b_tag_q <= pick_tag_q;
					end
					rd_pend_q <= 1'b0;
					if (CW'(i_q) + 1'b1 == count_q) begin
						state_q <= ST_FIN;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + 1'b1;
						state_q <= ST_LEAD;
					end
				end
				ST_FIN: begin
					if (found_q) begin
						out_q <= '{victim_valid: 1'b1, victim_tag: best_tag_q, retry_task: 1'b0,
							still_waiting: 1'b0, table_overflow: overflow_q};
						pend_valid_q <= 1'b1;
					end else if (have_q) begin
						out_q <= '{victim_valid: 1'b1, victim_tag: b_tag_q,
							retry_task: b_ret_q && b_cnt_q > CW'(1),
							still_waiting: 1'b0, table_overflow: overflow_q};
						pend_valid_q <= 1'b1;
					end else begin
						out_q <= '{victim_valid: 1'b0, victim_tag: '0, retry_task: 1'b0,
							still_waiting: 1'b0, table_overflow: overflow_q};
					end
					out_valid_q <= 1'b1;
					count_q <= '0;
					overflow_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WORKERS)) else $error("count beyond capacity");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("ready while walking");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> out_valid && count_q == '0) else $error("decide lost");
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.still_waiting |-> !out_data.victim_valid)
		else $error("waiting with victim");
endmodule
`default_nettype wire
